// File: hw/rtl/five_point_stencil_average_top_macros.svh
`ifndef FIVE_POINT_STENCIL_AVERAGE_TOP_MACROS_SVH
`define FIVE_POINT_STENCIL_AVERAGE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define FPSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpsa check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define FPSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpsa check failed");

`endif

// File: hw/rtl/fpsa_pkg.sv
package fpsa_pkg;

  localparam int MAX_COLS    = 2048;
  localparam int MAX_ROWS    = 2048;
  localparam int VALUE_WIDTH = 24;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W    = COL_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int COUNT_RESET = 2048;
  localparam int COL_RESET   = (MAX_COLS < COUNT_RESET) ? MAX_COLS : COUNT_RESET;
  localparam int ROW_RESET   = (MAX_ROWS < COUNT_RESET) ? MAX_ROWS : COUNT_RESET;
  localparam int COUNT_MIN   = 3;

  localparam int SUM_W     = VALUE_WIDTH + 3;
  localparam int MAG_W     = VALUE_WIDTH + 2;
  localparam int DIV_SHIFT = MAG_W + 3;
  localparam int RECIP_W   = MAG_W + 1;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV5_RECIP =
    RECIP_W'(((longint'(1) << DIV_SHIFT) + 4) / 5);

  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic   interior;
    logic   last;
    value_t pass;
  } side_t;

endpackage

// File: hw/rtl/fpsa_div5.sv
module fpsa_div5
  import fpsa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sum_t   in_sum_i,
  input  side_t  in_side_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output value_t out_cell_o,
  output logic   out_last_o
);

  logic v1_q, v2_q, v3_q, vo_q;
  logic r1, r2, r3, ro;

  sum_t  sum1_q;
  side_t side1_q, side2_q, side3_q;
  logic  neg2_q, neg3_q;
  logic [MAG_W-1:0]       mag2_q, mag_d;
  logic [VALUE_WIDTH-1:0] quo3_q, quo_d, quo_neg;
  logic [PROD_W-1:0]      prod;
  sum_t   abs_v;
  value_t cell_q, cell_d;
  logic   last_q;

  assign ro = !vo_q || out_ready_i;
  assign r3 = !v3_q || ro;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_comb begin
    abs_v = sum1_q[SUM_W-1] ? -sum1_q : sum1_q;
    mag_d = MAG_W'($unsigned(abs_v)) + MAG_W'(2);
  end

  assign prod  = PROD_W'(mag2_q) * PROD_W'(DIV5_RECIP);
  assign quo_d = prod[DIV_SHIFT +: VALUE_WIDTH];

  always_comb begin
    quo_neg = ~quo3_q + 1'b1;
    if (side3_q.interior) begin
      cell_d = neg3_q ? value_t'(quo_neg) : value_t'(quo3_q);
    end else begin
      cell_d = side3_q.pass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= (in_valid_i && r1) || (v1_q && !r2);
      v2_q <= (v1_q && r2) || (v2_q && !r3);
      v3_q <= (v2_q && r3) || (v3_q && !ro);
      vo_q <= (v3_q && ro) || (vo_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && r1) begin
      sum1_q  <= in_sum_i;
      side1_q <= in_side_i;
    end
    if (v1_q && r2) begin
      mag2_q  <= mag_d;
      neg2_q  <= sum1_q[SUM_W-1];
      side2_q <= side1_q;
    end
    if (v2_q && r3) begin
      quo3_q  <= quo_d;
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
    end
    if (v3_q && ro) begin
      cell_q <= cell_d;
      last_q <= side3_q.last;
    end
  end

  assign out_valid_o = vo_q;
  assign out_cell_o  = cell_q;
  assign out_last_o  = last_q;

endmodule

// File: hw/rtl/five_point_stencil_average_top.sv
// Five-point Jacobi stencil, one sweep over a grid streamed in raster order.
// One cell transfers per cycle while the output is not stalled; each interior
// result is the rounded average of the cell and its four neighbors, border
// cells are copied. Results come one row behind the input: row 0 yields
// nothing, and after the frame one row of drain items pushes out the last row,
// the final cell flagged by last_of_frame. A transfer that yields a result
// passes the line-store read register, then the sum, magnitude, quotient and
// output registers of the divide by five before it shows at the output. The
// line store is one two-row memory with one write and two read ports, so the
// block sustains one cell per cycle while the output is not stalled. A col_count
// or row_count write restarts the frame; counts below 3 act as 3, above the maximum as the maximum.
module five_point_stencil_average_top
  import fpsa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  value_t               cell_value_i,
  input  logic                 drain_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output value_t               cell_out_o,
  output logic                 last_of_frame_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [COL_CNT_W-1:0] cols_q;
  logic [ROW_W-1:0]     rows_q;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;

  value_t mem [MEM_DEPTH];
  value_t rd_a_q, rd_b_q, win_r_q, win_c_q;

  logic   s1_valid_q, s1_first_q, s1_interior_q, s1_last_q;
  value_t s1_below_q;

  logic in_accept, drain_phase, last_col, s1_load, mem_we, consume, s1_adv;
  logic cfg_hit, div_ready;
  logic [ADDR_W-1:0] addr_w, addr_a, addr_b;
  logic [COL_W-1:0]  col_next;
  logic [COL_CNT_W-1:0] cols_clamp;
  logic [ROW_W-1:0]     rows_clamp;
  logic interior;

  value_t center;
  sum_t   sum;
  side_t  side;

  assign in_ready_o  = !s1_valid_q || div_ready;
  assign in_accept   = in_valid_i && in_ready_o;
  assign drain_phase = row_q >= rows_q;
  assign last_col    = COL_CNT_W'(col_q) == (cols_q - COL_CNT_W'(1));
  assign consume     = drain_phase || !drain_i;
  assign s1_load     = in_accept && (drain_phase || (!drain_i && row_q != '0));
  assign mem_we      = in_accept && !drain_phase && !drain_i;
  assign interior    = !drain_phase && row_q >= ROW_W'(2) && col_q != '0 && !last_col;
  assign col_next    = col_q + 1'b1;

  assign addr_w = {row_q[0], col_q};
  assign addr_a = {~row_q[0], col_next};
  assign addr_b = (drain_phase || col_q == '0) ? {~row_q[0], col_q} : {row_q[0], col_q};

  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_COL_COUNT || cfg_index_i == CFG_ROW_COUNT);

  always_comb begin
    if (int'(cfg_data_i) < COUNT_MIN) begin
      cols_clamp = COL_CNT_W'(COUNT_MIN);
    end else if (int'(cfg_data_i) > MAX_COLS) begin
      cols_clamp = COL_CNT_W'(MAX_COLS);
    end else begin
      cols_clamp = COL_CNT_W'(cfg_data_i);
    end
    if (int'(cfg_data_i) < COUNT_MIN) begin
      rows_clamp = ROW_W'(COUNT_MIN);
    end else if (int'(cfg_data_i) > MAX_ROWS) begin
      rows_clamp = ROW_W'(MAX_ROWS);
    end else begin
      rows_clamp = ROW_W'(cfg_data_i);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept && consume) begin
      if (last_col) begin
        col_d = '0;
        row_d = drain_phase ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COL_CNT_W'(COL_RESET);
      rows_q     <= ROW_W'(ROW_RESET);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_COL_COUNT) begin
        cols_q <= cols_clamp;
      end
      if (cfg_we_i && cfg_index_i == CFG_ROW_COUNT) begin
        rows_q <= rows_clamp;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_load || (s1_valid_q && !div_ready);
    end
  end

  // line store: read before write on the same entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_w] <= cell_value_i;
    end
    if (s1_load) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_first_q    <= drain_phase || col_q == '0;
      s1_interior_q <= interior;
      s1_last_q     <= drain_phase && last_col;
      s1_below_q    <= cell_value_i;
    end
    if (s1_adv) begin
      win_r_q <= rd_a_q;
      win_c_q <= center;
    end
  end

  assign s1_adv = s1_valid_q && div_ready;
  assign center = s1_first_q ? rd_b_q : win_r_q;

  assign sum = SUM_W'(center) + SUM_W'(win_c_q) + SUM_W'(rd_a_q)
             + SUM_W'(rd_b_q) + SUM_W'(s1_below_q);

  assign side.interior = s1_interior_q;
  assign side.last     = s1_last_q;
  assign side.pass     = center;

  fpsa_div5 u_div5 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (div_ready),
    .in_sum_i    (sum),
    .in_side_i   (side),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_cell_o  (cell_out_o),
    .out_last_o  (last_of_frame_o)
  );

endmodule

// File: hw/rtl/fpsa_checker.sv
`include "five_point_stencil_average_top_macros.svh"

module fpsa_checker
  import fpsa_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready_o,
  input logic   out_valid_o,
  input logic   out_ready_i,
  input value_t cell_out_o,
  input logic   last_of_frame_o
);

  // input side stalls only when the whole pipe is backed up behind the output
  `FPSA_ASSERT_IMP(a_stall_from_output, !in_ready_o, out_valid_o && !out_ready_i)

  `FPSA_ASSERT_IMP(a_empty_after_reset, !$past(rst_ni), in_ready_o && !out_valid_o)

  `FPSA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(cell_out_o) && $stable(last_of_frame_o))

endmodule

bind five_point_stencil_average_top fpsa_checker u_fpsa_checker (.*);
